[sv/bsct_pkg.sv]
package bsct_pkg;

  // Button codes as they arrive on the input channel.
  localparam logic [2:0] BTN_NONE   = 3'd0;
  localparam logic [2:0] BTN_A      = 3'd1;
  localparam logic [2:0] BTN_A_LONG = 3'd2;
  localparam logic [2:0] BTN_B      = 3'd3;
  localparam logic [2:0] BTN_B_LONG = 3'd4;
  localparam logic [2:0] BTN_C      = 3'd5;

  // Codes of the run_state result field.
  localparam logic [2:0] RS_RESET    = 3'd0;
  localparam logic [2:0] RS_STARTED  = 3'd1;
  localparam logic [2:0] RS_STOPPED  = 3'd2;
  localparam logic [2:0] RS_TIMESET  = 3'd3;
  localparam logic [2:0] RS_FINISHED = 3'd4;

  // Configuration register indexes.
  localparam logic [2:0] CFG_SECONDS_LIMIT   = 3'd0;
  localparam logic [2:0] CFG_MINUTES_LIMIT   = 3'd1;
  localparam logic [2:0] CFG_FINISH_HOLD     = 3'd2;
  localparam logic [2:0] CFG_INITIAL_MINUTES = 3'd3;
  localparam logic [2:0] CFG_INITIAL_SECONDS = 3'd4;

  localparam logic [16:0] FINISH_MAX = 17'h1FFFF;

  typedef enum logic [4:0] {
    MODE_RESET    = 5'b00001,
    MODE_STARTED  = 5'b00010,
    MODE_STOPPED  = 5'b00100,
    MODE_TIMESET  = 5'b01000,
    MODE_FINISHED = 5'b10000
  } mode_t;

  typedef struct packed {
    logic [7:0]  seconds_limit;
    logic [7:0]  minutes_limit;
    logic [15:0] finish_hold_ms;
  } bsct_cfg_t;

  typedef struct packed {
    logic [2:0] run_state;
    logic       edit_field;
    logic [7:0] shown_minutes;
    logic [7:0] shown_seconds;
    logic       save_strobe;
    logic [7:0] preset_minutes_out;
    logic [7:0] preset_seconds_out;
  } bsct_res_t;

  typedef struct packed {
    logic [2:0] quot;
    logic [5:0] rem;
  } sec_split_t;

  // Splits an 8-bit seconds value into whole minutes (0 to 4) and leftover seconds.
  function automatic sec_split_t sec_split(input logic [7:0] s);
    sec_split_t r;
    if (s >= 8'd240) begin
      r.quot = 3'd4;
      r.rem  = 6'(s - 8'd240);
    end else if (s >= 8'd180) begin
      r.quot = 3'd3;
      r.rem  = 6'(s - 8'd180);
    end else if (s >= 8'd120) begin
      r.quot = 3'd2;
      r.rem  = 6'(s - 8'd120);
    end else if (s >= 8'd60) begin
      r.quot = 3'd1;
      r.rem  = 6'(s - 8'd60);
    end else begin
      r.quot = 3'd0;
      r.rem  = s[5:0];
    end
    return r;
  endfunction

  // One edit step on a minutes or seconds value, wrapping at the limit.
  function automatic logic [7:0] edit_value(input logic [7:0] v, input logic [7:0] limit,
                                            input logic [2:0] btn);
    logic [8:0]  up10;
    logic [7:0]  r;
    up10 = {1'b0, v} + 9'd10;
    unique case (btn)
      BTN_A:      r = (v < limit) ? v + 8'd1 : 8'd0;
      BTN_A_LONG: r = (up10 < {1'b0, limit}) ? up10[7:0] : 8'd0;
      BTN_B:      r = (v > 8'd0) ? v - 8'd1 : limit;
      BTN_B_LONG: r = (v > 8'd10) ? v - 8'd10 : limit;
      default:    r = v;
    endcase
    return r;
  endfunction

  function automatic logic [2:0] mode_code(input mode_t m);
    logic [2:0] r;
    unique case (m)
      MODE_RESET:    r = RS_RESET;
      MODE_STARTED:  r = RS_STARTED;
      MODE_STOPPED:  r = RS_STOPPED;
      MODE_TIMESET:  r = RS_TIMESET;
      MODE_FINISHED: r = RS_FINISHED;
      default:       r = RS_RESET;
    endcase
    return r;
  endfunction

endpackage

[sv/bsct_ifs.sv]
interface bsct_in_if;
  logic       valid;
  logic       ready;
  logic       tick;
  logic [2:0] button;

  modport source (output valid, output tick, output button, input ready);
  modport sink (input valid, input tick, input button, output ready);
endinterface

interface bsct_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] run_state;
  logic       edit_field;
  logic [7:0] shown_minutes;
  logic [7:0] shown_seconds;
  logic       save_strobe;
  logic [7:0] preset_minutes_out;
  logic [7:0] preset_seconds_out;

  modport source (output valid, output run_state, output edit_field, output shown_minutes,
                  output shown_seconds, output save_strobe, output preset_minutes_out,
                  output preset_seconds_out, input ready);
  modport sink (input valid, input run_state, input edit_field, input shown_minutes,
                input shown_seconds, input save_strobe, input preset_minutes_out,
                input preset_seconds_out, output ready);
endinterface

[sv/bsct_core.sv]
module bsct_core #(
  parameter int TICKS_PER_SECOND = 1000
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step,
  input  logic               tick,
  input  logic [2:0]         button,
  input  bsct_pkg::bsct_cfg_t cfg,
  output bsct_pkg::bsct_res_t res
);
  import bsct_pkg::*;

  localparam int SUB_W = (TICKS_PER_SECOND > 1) ? $clog2(TICKS_PER_SECOND) : 1;
  localparam logic [SUB_W-1:0] SUB_TOP = SUB_W'(TICKS_PER_SECOND - 1);
  localparam logic [SUB_W-1:0] SUB_ONE = SUB_W'(1);

  // The remaining time is held as minutes, seconds and sub-second ticks, plus a
  // flag for the one negative value it can reach.
  mode_t          mode_r, mode_nxt;
  logic           edit_r, edit_nxt;
  logic [7:0]     cur_min_r, cur_min_nxt, cur_sec_r, cur_sec_nxt;
  logic [7:0]     pre_min_r, pre_min_nxt, pre_sec_r, pre_sec_nxt;
  logic           neg_r, neg_nxt;
  logic [8:0]     rem_min_r, rem_min_nxt;
  logic [5:0]     rem_sec_r, rem_sec_nxt;
  logic [SUB_W-1:0] rem_sub_r, rem_sub_nxt;
  logic [16:0]    fin_cnt_r, fin_cnt_nxt;
  logic           strobe;
  logic [2:0]     btn;
  sec_split_t     sp;

  always_comb begin
    mode_nxt    = mode_r;
    edit_nxt    = edit_r;
    cur_min_nxt = cur_min_r;
    cur_sec_nxt = cur_sec_r;
    pre_min_nxt = pre_min_r;
    pre_sec_nxt = pre_sec_r;
    neg_nxt     = neg_r;
    rem_min_nxt = rem_min_r;
    rem_sec_nxt = rem_sec_r;
    rem_sub_nxt = rem_sub_r;
    fin_cnt_nxt = fin_cnt_r;
    strobe      = 1'b0;
    btn         = (button > BTN_C) ? BTN_NONE : button;
    sp          = sec_split(pre_sec_r);

    if (tick) begin
      if (mode_r == MODE_STARTED && !neg_r) begin
        if (rem_min_r == 9'd0 && rem_sec_r == 6'd0 && rem_sub_r == '0) begin
          neg_nxt = 1'b1;
        end else if (rem_sub_r != '0) begin
          rem_sub_nxt = rem_sub_r - SUB_ONE;
        end else begin
          rem_sub_nxt = SUB_TOP;
          if (rem_sec_r != 6'd0) begin
            rem_sec_nxt = rem_sec_r - 6'd1;
          end else begin
            rem_sec_nxt = 6'd59;
            rem_min_nxt = rem_min_r - 9'd1;
          end
        end
      end else if (mode_r == MODE_FINISHED && fin_cnt_r != FINISH_MAX) begin
        fin_cnt_nxt = fin_cnt_r + 17'd1;
      end
    end

    if (btn != BTN_NONE) begin
      unique case (mode_r)
        MODE_RESET: begin
          if (btn == BTN_A) begin
            mode_nxt = MODE_STARTED;
          end else if (btn == BTN_C) begin
            mode_nxt = MODE_TIMESET;
          end
        end
        MODE_STARTED: begin
          if (btn == BTN_A) begin
            mode_nxt = MODE_STOPPED;
          end
        end
        MODE_STOPPED: begin
          if (btn == BTN_A) begin
            mode_nxt = MODE_STARTED;
          end else if (btn == BTN_B || btn == BTN_C) begin
            neg_nxt     = 1'b0;
            rem_min_nxt = {1'b0, pre_min_r} + {6'd0, sp.quot};
            rem_sec_nxt = sp.rem;
            rem_sub_nxt = '0;
            cur_min_nxt = pre_min_r;
            cur_sec_nxt = pre_sec_r;
            edit_nxt    = 1'b0;
            mode_nxt    = (btn == BTN_C) ? MODE_TIMESET : MODE_RESET;
          end
        end
        MODE_TIMESET: begin
          if (!edit_r) begin
            if (btn == BTN_C) begin
              edit_nxt = 1'b1;
            end else begin
              cur_sec_nxt = edit_value(cur_sec_r, cfg.seconds_limit, btn);
            end
          end else if (btn == BTN_C) begin
            // Save the edited time as the new preset and restart from it.
            sp          = sec_split(cur_sec_r);
            pre_min_nxt = cur_min_r;
            pre_sec_nxt = cur_sec_r;
            strobe      = 1'b1;
            neg_nxt     = 1'b0;
            rem_min_nxt = {1'b0, cur_min_r} + {6'd0, sp.quot};
            rem_sec_nxt = sp.rem;
            rem_sub_nxt = '0;
            edit_nxt    = 1'b0;
            mode_nxt    = MODE_RESET;
          end else begin
            cur_min_nxt = edit_value(cur_min_r, cfg.minutes_limit, btn);
          end
        end
        MODE_FINISHED: begin
          neg_nxt     = 1'b0;
          rem_min_nxt = {1'b0, pre_min_r} + {6'd0, sp.quot};
          rem_sec_nxt = sp.rem;
          rem_sub_nxt = '0;
          cur_min_nxt = pre_min_r;
          cur_sec_nxt = pre_sec_r;
          edit_nxt    = 1'b0;
          mode_nxt    = MODE_RESET;
        end
        default: begin
          mode_nxt = mode_r;
        end
      endcase
    end

    if (mode_nxt == MODE_STARTED) begin
      if (neg_nxt) begin
        mode_nxt    = MODE_FINISHED;
        fin_cnt_nxt = 17'd0;
      end else if (rem_min_nxt > 9'd255) begin
        cur_min_nxt = 8'd255;
        cur_sec_nxt = 8'd59;
      end else begin
        cur_min_nxt = rem_min_nxt[7:0];
        cur_sec_nxt = {2'b00, rem_sec_nxt};
      end
    end else if (mode_nxt == MODE_FINISHED && fin_cnt_nxt > {1'b0, cfg.finish_hold_ms}) begin
      // Only reached from finished, so the preset is the stored one.
      neg_nxt     = 1'b0;
      rem_min_nxt = {1'b0, pre_min_r} + {6'd0, sp.quot};
      rem_sec_nxt = sp.rem;
      rem_sub_nxt = '0;
      cur_min_nxt = pre_min_r;
      cur_sec_nxt = pre_sec_r;
      edit_nxt    = 1'b0;
      mode_nxt    = MODE_RESET;
    end

    res.run_state          = mode_code(mode_nxt);
    res.edit_field         = edit_nxt;
    res.shown_minutes      = cur_min_nxt;
    res.shown_seconds      = cur_sec_nxt;
    res.save_strobe        = strobe;
    res.preset_minutes_out = pre_min_nxt;
    res.preset_seconds_out = pre_sec_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_RESET;
      edit_r    <= 1'b0;
      cur_min_r <= 8'd0;
      cur_sec_r <= 8'd0;
      pre_min_r <= 8'd0;
      pre_sec_r <= 8'd0;
      neg_r     <= 1'b0;
      rem_min_r <= 9'd0;
      rem_sec_r <= 6'd0;
      rem_sub_r <= '0;
      fin_cnt_r <= 17'd0;
    end else if (step) begin
      mode_r    <= mode_nxt;
      edit_r    <= edit_nxt;
      cur_min_r <= cur_min_nxt;
      cur_sec_r <= cur_sec_nxt;
      pre_min_r <= pre_min_nxt;
      pre_sec_r <= pre_sec_nxt;
      neg_r     <= neg_nxt;
      rem_min_r <= rem_min_nxt;
      rem_sec_r <= rem_sec_nxt;
      rem_sub_r <= rem_sub_nxt;
      fin_cnt_r <= fin_cnt_nxt;
    end
  end

endmodule

[sv/button_set_countdown_timer_top.sv]
// Minutes:seconds countdown timer driven by millisecond ticks and button events.
// Each item on in_ch carries a tick flag (one millisecond has passed) and a
// button code; for every item exactly one result item leaves on out_ch with the
// run state, the field being edited, the shown time, a save strobe and the
// preset that should be written to nonvolatile storage when the strobe is set.
// Both channels use a valid/ready handshake. An item is captured in an input
// register, worked on by the core and written to an output register, which
// offers its result on out_ch. One item is taken every cycle while the
// receiver does not stall; the state update in the core sets that rate.
// While the receiver stalls, the result waits in the output register, one
// more item can sit in the input register, and in_ch.ready drops only when
// both are full. Synchronous reset (rst_n low) empties both registers,
// returns the limits and hold time to 59, 99 and 5000, and puts the timer in
// reset mode with a zero preset. Writes to the initial preset indexes are
// ignored, so a preset of zero always follows reset. The user must write
// configuration on the cfg_ port only while no item is in flight; the block
// does not enforce this.
module button_set_countdown_timer_top #(
  parameter int TICKS_PER_SECOND = 1000
) (
  input  logic              clk,
  input  logic              rst_n,
  bsct_in_if.sink           in_ch,
  bsct_out_if.source        out_ch,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [15:0]       cfg_wdata
);
  import bsct_pkg::*;

  bsct_cfg_t  cfg_r;
  logic       s1_valid_r;
  logic       s1_tick_r;
  logic [2:0] s1_button_r;
  logic       out_valid_r;
  bsct_res_t  out_res_r;
  bsct_res_t  core_res;
  logic       advance;

  // The worked item moves on when the output register is empty or being read.
  assign advance     = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.seconds_limit  <= 8'd59;
      cfg_r.minutes_limit  <= 8'd99;
      cfg_r.finish_hold_ms <= 16'd5000;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SECONDS_LIMIT: cfg_r.seconds_limit  <= cfg_wdata[7:0];
        CFG_MINUTES_LIMIT: cfg_r.minutes_limit  <= cfg_wdata[7:0];
        CFG_FINISH_HOLD:   cfg_r.finish_hold_ms <= cfg_wdata;
        default:           cfg_r                <= cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_tick_r   <= in_ch.tick;
      s1_button_r <= in_ch.button;
    end
  end

  bsct_core #(
    .TICKS_PER_SECOND(TICKS_PER_SECOND)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (advance),
    .tick   (s1_tick_r),
    .button (s1_button_r),
    .cfg    (cfg_r),
    .res    (core_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res_r <= core_res;
    end
  end

  assign out_ch.valid              = out_valid_r;
  assign out_ch.run_state          = out_res_r.run_state;
  assign out_ch.edit_field         = out_res_r.edit_field;
  assign out_ch.shown_minutes      = out_res_r.shown_minutes;
  assign out_ch.shown_seconds      = out_res_r.shown_seconds;
  assign out_ch.save_strobe        = out_res_r.save_strobe;
  assign out_ch.preset_minutes_out = out_res_r.preset_minutes_out;
  assign out_ch.preset_seconds_out = out_res_r.preset_seconds_out;

endmodule
